/* hdl/hhc_pkg.sv */
// ----------------------------------------------------------------------------
// hhc_pkg
// Shared types, codes and widths for the heat-then-hold cycle controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hhc_pkg;

	localparam int KIND_W   = 3;
	localparam int TEMP_W   = 12;
	localparam int TGT_W    = 11;
	localparam int MARGIN_W = 10;
	localparam int SEC_W    = 20;
	localparam int PHASE_W  = 3;
	localparam int FAULT_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;
	// temperature compares run at this width so target plus margin never wraps
	localparam int CMP_W    = 14;
	localparam int HYST_TENTHS = 10;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ESTOP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERRRST = 3'd4;

	// phases
	localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HEAT = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HOLD = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DONE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ERR  = 3'd4;

	// fault causes
	localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_ABS    = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_MARGIN = 2'd2;
	localparam logic [FAULT_W-1:0] FAULT_ESTOP  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd3;

	localparam logic [TGT_W-1:0]    LIMIT_RESET  = 11'd1500;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;
	localparam logic [SEC_W-1:0]    SEC_MAX      = {SEC_W{1'b1}};

	typedef struct packed {
		logic [TGT_W-1:0]    target;
		logic [SEC_W-1:0]    hold;
		logic [TGT_W-1:0]    limit;
		logic [MARGIN_W-1:0] margin;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               heater;
		logic [SEC_W-1:0]   elapsed;
		logic [FAULT_W-1:0] fault;
	} state_t;

endpackage

`default_nettype wire

/* hdl/hhc_cfg.sv */
// ----------------------------------------------------------------------------
// hhc_cfg
// Configuration register file: target, hold time, absolute limit and margin.
// ----------------------------------------------------------------------------
`default_nettype none

module hhc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           we,
	input  wire logic [hhc_pkg::CFG_IDX_W-1:0]  idx,
	input  wire logic [hhc_pkg::CFG_DAT_W-1:0]  wdata,
	output hhc_pkg::cfg_t                       cfg
);
	import hhc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= '0;
			cfg_q.hold   <= '0;
			cfg_q.limit  <= LIMIT_RESET;
			cfg_q.margin <= MARGIN_RESET;
		end else if (we) begin
			case (idx)
				REG_TARGET: cfg_q.target <= wdata[TGT_W-1:0];
				REG_HOLD:   cfg_q.hold   <= wdata[SEC_W-1:0];
				REG_LIMIT:  cfg_q.limit  <= wdata[TGT_W-1:0];
				REG_MARGIN: cfg_q.margin <= wdata[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hdl/hhc_step.sv */
// ----------------------------------------------------------------------------
// hhc_step
// Next-state logic for one word: phase transitions, overheat trips, hold
// hysteresis and the elapsed-seconds counter, plus the remaining-time value.
// ----------------------------------------------------------------------------
`default_nettype none

module hhc_step (
	input  wire hhc_pkg::state_t                   cur,
	input  wire hhc_pkg::cfg_t                     cfg,
	input  wire logic [hhc_pkg::KIND_W-1:0]        kind,
	input  wire logic signed [hhc_pkg::TEMP_W-1:0] sample,
	output hhc_pkg::state_t                        nxt,
	output logic [hhc_pkg::SEC_W-1:0]              remaining
);
	import hhc_pkg::*;

	logic signed [CMP_W-1:0] t_x;
	logic signed [CMP_W-1:0] tgt_x;
	logic signed [CMP_W-1:0] lim_x;
	logic signed [CMP_W-1:0] trip_x;
	logic signed [CMP_W-1:0] lo_x;
	logic signed [CMP_W-1:0] hi_x;
	logic [SEC_W-1:0]        elapsed_new;
	logic                    entered;

	assign t_x    = CMP_W'(sample);
	assign tgt_x  = $signed({{(CMP_W-TGT_W){1'b0}}, cfg.target});
	assign lim_x  = $signed({{(CMP_W-TGT_W){1'b0}}, cfg.limit});
	assign trip_x = tgt_x + $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg.margin});
	assign lo_x   = tgt_x - CMP_W'(HYST_TENTHS);
	assign hi_x   = tgt_x + CMP_W'(HYST_TENTHS);

	always_comb begin
		nxt         = cur;
		entered     = 1'b0;
		elapsed_new = cur.elapsed;
		case (kind)
			KIND_TICK: begin
				if (cur.phase != PH_ERR) begin
					if (t_x >= lim_x) begin
						nxt.phase  = PH_ERR;
						nxt.heater = 1'b0;
						nxt.fault  = FAULT_ABS;
					end else if (t_x >= trip_x) begin
						nxt.phase  = PH_ERR;
						nxt.heater = 1'b0;
						nxt.fault  = FAULT_MARGIN;
					end else begin
						if (cur.phase == PH_HEAT && t_x >= tgt_x) begin
							nxt.phase  = PH_HOLD;
							nxt.heater = 1'b0;
							entered    = 1'b1;
							elapsed_new = '0;
						end
						if (nxt.phase == PH_HOLD) begin
							// no count on the tick that enters hold
							if (!entered && cur.elapsed != SEC_MAX)
								elapsed_new = cur.elapsed + 1'b1;
							nxt.elapsed = elapsed_new;
							if (t_x <= lo_x)
								nxt.heater = 1'b1;
							else if (t_x >= hi_x)
								nxt.heater = 1'b0;
							if (elapsed_new >= cfg.hold)
								nxt.phase = PH_DONE;
						end
					end
				end
			end
			KIND_START: begin
				if (cur.phase == PH_IDLE) begin
					nxt.phase  = PH_HEAT;
					nxt.heater = 1'b1;
				end
			end
			KIND_STOP: begin
				nxt.phase  = PH_IDLE;
				nxt.heater = 1'b0;
				nxt.fault  = FAULT_NONE;
			end
			KIND_ESTOP: begin
				nxt.phase  = PH_ERR;
				nxt.heater = 1'b0;
				nxt.fault  = FAULT_ESTOP;
			end
			KIND_ERRRST: begin
				if (cur.phase == PH_ERR) begin
					nxt.phase  = PH_IDLE;
					nxt.heater = 1'b0;
					nxt.fault  = FAULT_NONE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (nxt.phase)
			PH_IDLE, PH_HEAT: remaining = cfg.hold;
			PH_HOLD:
				remaining = (cfg.hold > nxt.elapsed) ? cfg.hold - nxt.elapsed : '0;
			default: remaining = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/heat_hold_cycle_controller_unit.sv */
// ----------------------------------------------------------------------------
// heat_hold_cycle_controller_unit
// Heat-then-hold cycle controller with overheat trips and timed hold.
// ----------------------------------------------------------------------------
// Takes one word per clock unless back-pressure on m_tready stalls it: a
// one-second tick or a command in s_tuser and a temperature sample in tenths
// of a degree in s_tdata. Each word gives one result word with the phase,
// heater drive, hold seconds remaining and fault cause as they stand after
// that word. A word is held in the input register, and its result is taken
// into the output register as the controller state updates. The output
// register lets a new word be taken while a result still waits on m_tready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
`default_nettype none

module heat_hold_cycle_controller_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] sample_tenths, [15:12] zero
	input  wire logic [2:0]  s_tuser,   // [2:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [2:0] phase, [3] heater_on,
	                                    // [23:4] remaining_seconds,
	                                    // [25:24] fault_cause, [31:26] zero
);
	import hhc_pkg::*;

	cfg_t cfg;
	state_t state_q;
	state_t state_nxt;
	logic [SEC_W-1:0] remaining;

	logic                     item_valid_s1;
	logic [KIND_W-1:0]        kind_s1;
	logic signed [TEMP_W-1:0] sample_s1;

	logic                     res_valid_s2;
	logic [PHASE_W-1:0]       phase_s2;
	logic                     heater_s2;
	logic [SEC_W-1:0]         remaining_s2;
	logic [FAULT_W-1:0]       fault_s2;

	logic out_free;
	logic adv;

	hhc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	hhc_step u_step (
		.cur       (state_q),
		.cfg       (cfg),
		.kind      (kind_s1),
		.sample    (sample_s1),
		.nxt       (state_nxt),
		.remaining (remaining)
	);

	assign out_free = !res_valid_s2 || m_tready;
	assign adv      = item_valid_s1 && out_free;
	assign s_tready = !item_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= s_tuser;
			sample_s1 <= s_tdata[TEMP_W-1:0];
		end
	end

	// controller state moves only when its word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_IDLE;
			state_q.heater  <= 1'b0;
			state_q.elapsed <= '0;
			state_q.fault   <= FAULT_NONE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2     <= state_nxt.phase;
			heater_s2    <= state_nxt.heater;
			remaining_s2 <= remaining;
			fault_s2     <= state_nxt.fault;
		end
	end

	assign m_tvalid = res_valid_s2;
	assign m_tdata  = {6'd0, fault_s2, remaining_s2, heater_s2, phase_s2};

endmodule

`default_nettype wire
